[hw/rtl/assert_macros.svh]
// assertion macros shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property on the module clock, off during reset
`define GLQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication
`define GLQ_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define GLQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/glq_pkg.sv]
// shared types and constants of the glyph quad layout block
package glq_pkg;

  localparam logic [7:0] FIRST_CODE   = 8'd32;
  localparam logic [7:0] END_CODE     = 8'd128;
  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam int NORM_SHIFT = 15;
  localparam int POS_W      = 14;
  localparam int GIDX_W     = 7;

  typedef enum logic [1:0] {
    FN_START  = 2'd0,
    FN_CHAR   = 2'd1,
    FN_METRIC = 2'd2,
    FN_TEX    = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    CFG_SCREEN_W = 3'd0,
    CFG_SCREEN_H = 3'd1,
    CFG_LINE_H   = 3'd2,
    CFG_LINE_GAP = 3'd3,
    CFG_MAX_CHARS = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [11:0] screen_width;
    logic [11:0] screen_height;
    logic [7:0]  line_height;
    logic [7:0]  line_gap;
    logic [15:0] max_chars;
  } cfg_t;

  typedef struct packed {
    logic [7:0] width;
    logic [7:0] height;
    logic [7:0] advance;
    logic [7:0] bearing_left;
    logic [7:0] bearing_top;
  } metric_t;

  typedef struct packed {
    logic                    is_tex;
    logic [15:0]             quad_index;
    logic signed [POS_W-1:0] x0;
    logic signed [POS_W-1:0] x1;
    logic signed [POS_W-1:0] y0;
    logic signed [POS_W-1:0] y1;
    logic [GIDX_W-1:0]       gidx;
    logic [1:0]              corner;
    logic [15:0]             tex_s;
    logic [15:0]             tex_t;
  } job_t;

endpackage

[hw/rtl/glq_in_if.sv]
// input and output stream interfaces of the glyph quad layout block
interface glq_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        func;
  logic [7:0]        char_code;
  logic [7:0]        glyph_width;
  logic [7:0]        glyph_height;
  logic [7:0]        advance;
  logic signed [7:0] bearing_left;
  logic signed [7:0] bearing_top;
  logic [1:0]        corner_sel;
  logic [15:0]       tex_s_in;
  logic [15:0]       tex_t_in;

  modport source (output valid, func, char_code, glyph_width, glyph_height, advance,
                  bearing_left, bearing_top, corner_sel, tex_s_in, tex_t_in,
                  input ready);
  modport sink (input valid, func, char_code, glyph_width, glyph_height, advance,
                bearing_left, bearing_top, corner_sel, tex_s_in, tex_t_in,
                output ready);
endinterface

interface glq_out_if;
  logic               valid;
  logic               ready;
  logic [15:0]        quad_index;
  logic [1:0]         corner;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic [15:0]        tex_s;
  logic [15:0]        tex_t;
  logic               last_vertex;

  modport source (output valid, quad_index, corner, pos_x, pos_y, tex_s, tex_t,
                  last_vertex, input ready);
  modport sink (input valid, quad_index, corner, pos_x, pos_y, tex_s, tex_t,
                last_vertex, output ready);
endinterface

[hw/rtl/glq_front.sv]
// front end: accepts items, holds glyph metrics and pen state, issues quad and texcoord jobs
`include "assert_macros.svh"
module glq_front import glq_pkg::*; #(
  parameter int GLYPH_COUNT = 96
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  glq_in_if.sink     in_i,
  input  cfg_t       cfg_i,
  output job_t       job_o,
  output logic       push_o,
  input  logic       full_i
);

  localparam int GIW = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;

  typedef enum logic {S_IDLE, S_EXEC} state_e;

  state_e      state_q;
  logic        stop_q, stop_d;
  logic [15:0] pen_x_q, pen_x_d, pen_y_q, pen_y_d;
  logic [15:0] seen_q, seen_d, quads_q, quads_d;
  logic [1:0]  func_q;
  logic [7:0]  code_q;
  logic        rng_q;
  logic [GIW-1:0] gidx_q;
  logic [1:0]  csel_q;
  logic [15:0] s_q, t_q;
  metric_t     met_mem [GLYPH_COUNT];
  metric_t     met_q;

  logic        in_fire, in_rng, done, push_req;
  logic [7:0]  off;
  logic [16:0] px_sum;
  logic [17:0] py_sum, clip_y;
  logic [17:0] x0w, x1w, y0w, y1w;

  assign in_fire = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == S_IDLE);
  assign off = in_i.char_code - FIRST_CODE;
  assign in_rng = (in_i.char_code >= FIRST_CODE) && (off < 8'(GLYPH_COUNT));

  always_ff @(posedge clk_i) begin
    if (in_fire && in_i.func == FN_METRIC && in_rng) begin
      met_mem[off[GIW-1:0]] <= {in_i.glyph_width, in_i.glyph_height, in_i.advance,
                                in_i.bearing_left, in_i.bearing_top};
    end
    if (in_fire) begin
      met_q  <= met_mem[off[GIW-1:0]];
      func_q <= in_i.func;
      code_q <= in_i.char_code;
      rng_q  <= in_rng;
      gidx_q <= off[GIW-1:0];
      csel_q <= in_i.corner_sel;
      s_q    <= in_i.tex_s_in;
      t_q    <= in_i.tex_t_in;
    end
  end

  assign px_sum = {1'b0, pen_x_q} + 17'(met_q.advance);
  assign py_sum = {2'b0, pen_y_q} + 18'(cfg_i.line_height) + 18'(cfg_i.line_gap);
  assign clip_y = {2'b0, pen_y_q} + 18'(met_q.height) + 18'(cfg_i.line_gap);
  assign x0w = {2'b0, pen_x_q} + {{10{met_q.bearing_left[7]}}, met_q.bearing_left};
  assign x1w = x0w + 18'(met_q.width);
  assign y0w = {2'b0, pen_y_q} - {{10{met_q.bearing_top[7]}}, met_q.bearing_top};
  assign y1w = y0w + 18'(met_q.height);

  always_comb begin
    pen_x_d  = pen_x_q;
    pen_y_d  = pen_y_q;
    seen_d   = seen_q;
    quads_d  = quads_q;
    stop_d   = stop_q;
    push_req = 1'b0;
    done     = 1'b1;
    job_o            = '0;
    job_o.quad_index = quads_q;
    job_o.x0         = x0w[POS_W-1:0];
    job_o.x1         = x1w[POS_W-1:0];
    job_o.y0         = y0w[POS_W-1:0];
    job_o.y1         = y1w[POS_W-1:0];
    job_o.gidx       = GIDX_W'(gidx_q);
    job_o.corner     = csel_q;
    job_o.tex_s      = s_q;
    job_o.tex_t      = t_q;
    case (func_e'(func_q))
      FN_START: begin
        pen_x_d = '0;
        pen_y_d = {8'b0, cfg_i.line_height};
        seen_d  = '0;
        quads_d = '0;
        stop_d  = 1'b0;
      end
      FN_CHAR: begin
        if (!stop_q) begin
          if (code_q == 8'd0 || (cfg_i.max_chars != 16'd0 && seen_q >= cfg_i.max_chars)) begin
            stop_d = 1'b1;
          end else begin
            seen_d = (seen_q == 16'hffff) ? seen_q : seen_q + 16'd1;
            if (code_q == NEWLINE_CODE) begin
              pen_x_d = '0;
              pen_y_d = (|py_sum[17:16]) ? 16'hffff : py_sum[15:0];
            end else if (rng_q && code_q < END_CODE) begin
              if (met_q.width == 8'd0 || met_q.height == 8'd0) begin
                pen_x_d = px_sum[16] ? 16'hffff : px_sum[15:0];
              end else if (clip_y >= 18'(cfg_i.screen_height) ||
                           px_sum >= 17'(cfg_i.screen_width)) begin
                stop_d = 1'b1;
              end else begin
                push_req = 1'b1;
                pen_x_d  = px_sum[16] ? 16'hffff : px_sum[15:0];
                quads_d  = quads_q + 16'd1;
              end
            end
          end
        end
      end
      FN_TEX: begin
        push_req     = rng_q;
        job_o.is_tex = 1'b1;
      end
      default: ;
    endcase
    if (push_req && full_i) begin
      pen_x_d = pen_x_q;
      pen_y_d = pen_y_q;
      seen_d  = seen_q;
      quads_d = quads_q;
      stop_d  = stop_q;
      done    = 1'b0;
    end
  end

  assign push_o = (state_q == S_EXEC) && push_req && !full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      stop_q  <= 1'b1;
      pen_x_q <= '0;
      pen_y_q <= '0;
      seen_q  <= '0;
      quads_q <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_fire) state_q <= S_EXEC;
        end
        S_EXEC: begin
          if (done) begin
            state_q <= S_IDLE;
            stop_q  <= stop_d;
            pen_x_q <= pen_x_d;
            pen_y_q <= pen_y_d;
            seen_q  <= seen_d;
            quads_q <= quads_d;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `GLQ_ASSERT_IMPL(a_no_push_stopped, state_q == S_EXEC && func_q == FN_CHAR && stop_q, !push_o, "quad issued while run stopped")
  `GLQ_ASSERT_IMPL(a_push_not_full, push_o, !full_i, "job pushed into full queue")

endmodule

[hw/rtl/glq_fifo.sv]
// two-entry job queue between front and back
`include "assert_macros.svh"
module glq_fifo import glq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  job_t job_i,
  input  logic push_i,
  output logic full_o,
  output job_t job_o,
  output logic empty_o,
  input  logic pop_i
);

  localparam int DEPTH = 2;
  localparam int PW = $clog2(DEPTH);

  job_t            mem_q [DEPTH];
  logic [PW-1:0]   wr_q, rd_q;
  logic [PW:0]     count_q;
  logic            do_push, do_pop;

  assign full_o  = (count_q == (PW+1)'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign job_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop)  rd_q <= rd_q + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: ;
      endcase
    end
  end

  `GLQ_ASSERT_NEXT(a_count_up, do_push && !do_pop, count_q == $past(count_q) + 1'b1, "queue count did not grow")
  `GLQ_ASSERT(a_count_range, count_q <= (PW+1)'(DEPTH), "queue count beyond depth")

endmodule

[hw/rtl/glq_back.sv]
// back end: divides corner positions, holds texcoords, emits four vertices per quad
`include "assert_macros.svh"
module glq_back import glq_pkg::*; #(
  parameter int GLYPH_COUNT = 96,
  parameter int COORD_BITS  = 16
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  job_t   job_i,
  input  logic   empty_i,
  output logic   pop_o,
  input  cfg_t   cfg_i,
  glq_out_if.source out_o
);

  localparam int GIW = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;
  localparam int AW  = GIW + 2;
  localparam int NW  = POS_W + NORM_SHIFT;

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_RD, S_OUT} state_e;

  state_e      state_q;
  logic [2:0]  cnt_q;
  logic [1:0]  corner_q;
  logic [15:0] qidx_q;
  logic [GIW-1:0] gidx_q;
  logic [11:0] rem_q [4];
  logic [15:0] num_q [4];
  logic [15:0] quo_q [4];
  logic        neg_q [4];
  logic        sat_q [4];
  logic [11:0] rem_d [4];
  logic [15:0] num_d [4];
  logic [15:0] quo_d [4];
  logic [15:0] res   [4];
  logic signed [POS_W-1:0] pos_in [4];
  logic [POS_W-1:0] mag [4];
  logic [NW-1:0]    nval [4];
  logic [11:0] dvs [4];

  logic [2*COORD_BITS-1:0] tex_mem [GLYPH_COUNT*4];
  logic [2*COORD_BITS-1:0] tex_rd_q;
  logic [AW-1:0] rd_addr, wr_addr;

  logic        out_valid_q, load;
  logic [15:0] o_qidx_q, o_px_q, o_py_q, o_s_q, o_t_q;
  logic [1:0]  o_corner_q;

  assign pop_o = (state_q == S_IDLE) && !empty_i;
  assign load  = (state_q == S_OUT) && (!out_valid_q || out_o.ready);

  assign pos_in[0] = job_i.x0;
  assign pos_in[1] = job_i.x1;
  assign pos_in[2] = job_i.y0;
  assign pos_in[3] = job_i.y1;
  assign dvs[0] = cfg_i.screen_width;
  assign dvs[1] = cfg_i.screen_width;
  assign dvs[2] = cfg_i.screen_height;
  assign dvs[3] = cfg_i.screen_height;

  always_comb begin
    logic [12:0] tr;
    logic [11:0] r;
    logic [15:0] n, q;
    for (int i = 0; i < 4; i++) begin
      mag[i]  = pos_in[i][POS_W-1] ? POS_W'(-pos_in[i]) : pos_in[i];
      nval[i] = {mag[i], {NORM_SHIFT{1'b0}}} - NW'(mag[i]);
      r = rem_q[i];
      n = num_q[i];
      q = quo_q[i];
      for (int k = 0; k < 2; k++) begin
        tr = {r, n[15]};
        n  = {n[14:0], 1'b0};
        if (tr >= {1'b0, dvs[i]}) begin
          r = 12'(tr - {1'b0, dvs[i]});
          q = {q[14:0], 1'b1};
        end else begin
          r = tr[11:0];
          q = {q[14:0], 1'b0};
        end
      end
      rem_d[i] = r;
      num_d[i] = n;
      quo_d[i] = q;
      if (sat_q[i]) begin
        res[i] = neg_q[i] ? 16'h8000 : 16'h7fff;
      end else begin
        res[i] = neg_q[i] ? -quo_q[i] : quo_q[i];
      end
    end
  end

  assign rd_addr = {gidx_q, corner_q};
  assign wr_addr = {job_i.gidx[GIW-1:0], job_i.corner};

  always_ff @(posedge clk_i) begin
    if (pop_o && job_i.is_tex) begin
      tex_mem[wr_addr] <= {job_i.tex_s[COORD_BITS-1:0], job_i.tex_t[COORD_BITS-1:0]};
    end
    if (state_q == S_RD) tex_rd_q <= tex_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && !job_i.is_tex) begin
      qidx_q <= job_i.quad_index;
      gidx_q <= job_i.gidx[GIW-1:0];
      for (int i = 0; i < 4; i++) begin
        neg_q[i] <= pos_in[i][POS_W-1];
        sat_q[i] <= 13'(mag[i]) > {1'b0, dvs[i]};
        rem_q[i] <= nval[i][27:16];
        num_q[i] <= nval[i][15:0];
        quo_q[i] <= '0;
      end
    end else if (state_q == S_DIV) begin
      for (int i = 0; i < 4; i++) begin
        rem_q[i] <= rem_d[i];
        num_q[i] <= num_d[i];
        quo_q[i] <= quo_d[i];
      end
    end
    if (load) begin
      o_qidx_q   <= qidx_q;
      o_corner_q <= corner_q;
      o_px_q     <= res[{1'b0, corner_q[0]}];
      o_py_q     <= res[{1'b1, corner_q[1]}];
      o_s_q      <= 16'(tex_rd_q[2*COORD_BITS-1:COORD_BITS]);
      o_t_q      <= 16'(tex_rd_q[COORD_BITS-1:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      corner_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (pop_o && !job_i.is_tex) begin
            state_q <= S_DIV;
            cnt_q   <= '0;
          end
        end
        S_DIV: begin
          cnt_q <= cnt_q + 3'd1;
          if (cnt_q == 3'd7) begin
            state_q  <= S_RD;
            corner_q <= '0;
          end
        end
        S_RD: state_q <= S_OUT;
        S_OUT: begin
          if (load) begin
            corner_q <= corner_q + 2'd1;
            state_q  <= (corner_q == 2'd3) ? S_IDLE : S_RD;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.quad_index  = o_qidx_q;
  assign out_o.corner      = o_corner_q;
  assign out_o.pos_x       = o_px_q;
  assign out_o.pos_y       = o_py_q;
  assign out_o.tex_s       = o_s_q;
  assign out_o.tex_t       = o_t_q;
  assign out_o.last_vertex = (o_corner_q == 2'd3);

  `GLQ_ASSERT_NEXT(a_last_to_idle, load && corner_q == 2'd3, state_q == S_IDLE, "back did not finish quad")
  `GLQ_ASSERT_IMPL(a_no_pop_busy, state_q != S_IDLE, !pop_o, "job popped while busy")

endmodule

[hw/rtl/glyph_quad_layout.sv]
// top level of the glyph quad layout block: configuration registers and wiring
//
// in_i carries one item per transfer: start string, character, glyph metric
// write or glyph texcoord write. out_o carries one vertex per transfer, four
// per visible glyph, corners in order top-left, top-right, bottom-left,
// bottom-right, the last one flagged by last_vertex.
// The front end takes an item in its idle state and resolves it in its exec
// state, which holds while the job queue is full; it takes no new item until
// the last one is resolved. A visible glyph then waits in a two-entry job
// queue for the back end, which pops it while idle, divides all four corner
// positions in parallel at two quotient bits a cycle and then, once per
// corner, reads the texcoord memory and loads the output register, waiting
// while out_o stalls; it pops no new job until the last vertex is loaded.
// The cfg port writes the register cfg_idx_i names; write it only while idle.
// Reset puts the registers at their defaults and stops the run until a start
// item arrives; glyph tables are not cleared. When out_o stalls, the output
// register holds, the back end waits, and the queue then the front end fill.
module glyph_quad_layout import glq_pkg::*; #(
  parameter int GLYPH_COUNT = 96,
  parameter int COORD_BITS  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  glq_in_if.sink      in_i,
  glq_out_if.source   out_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i
);

  cfg_t cfg_q;
  job_t f_job, q_job;
  logic f_push, q_full, q_empty, b_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.screen_width  <= 12'd640;
      cfg_q.screen_height <= 12'd480;
      cfg_q.line_height   <= 8'd16;
      cfg_q.line_gap      <= 8'd0;
      cfg_q.max_chars     <= 16'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_SCREEN_W:  cfg_q.screen_width  <= cfg_wdata_i[11:0];
        CFG_SCREEN_H:  cfg_q.screen_height <= cfg_wdata_i[11:0];
        CFG_LINE_H:    cfg_q.line_height   <= cfg_wdata_i[7:0];
        CFG_LINE_GAP:  cfg_q.line_gap      <= cfg_wdata_i[7:0];
        CFG_MAX_CHARS: cfg_q.max_chars     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  glq_front #(.GLYPH_COUNT(GLYPH_COUNT)) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .cfg_i  (cfg_q),
    .job_o  (f_job),
    .push_o (f_push),
    .full_i (q_full)
  );

  glq_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .job_i   (f_job),
    .push_i  (f_push),
    .full_o  (q_full),
    .job_o   (q_job),
    .empty_o (q_empty),
    .pop_i   (b_pop)
  );

  glq_back #(.GLYPH_COUNT(GLYPH_COUNT), .COORD_BITS(COORD_BITS)) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .job_i   (q_job),
    .empty_i (q_empty),
    .pop_o   (b_pop),
    .cfg_i   (cfg_q),
    .out_o   (out_o)
  );

endmodule
